// File: hw/rtl/tri_pkg.sv
// ----------------------------------------------------------------------------
// tri_pkg
// Shared types and codes of the trie insert/lookup core.
// ----------------------------------------------------------------------------
package tri_pkg;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_CHECK  = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef struct packed {
		cmd_t       command;
		logic [7:0] symbol;
		logic       last;
		logic       empty_req;
	} item_t;

	typedef struct packed {
		cmd_t       done_kind;
		logic       found;
		logic       full_res;
		logic [9:0] end_node;
	} result_t;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_LOOK,
		ST_CMP,
		ST_TAIL,
		ST_FIN
	} eng_state_t;

endpackage

// File: hw/rtl/trie_insert_lookup_core.sv
// ----------------------------------------------------------------------------
// trie_insert_lookup_core
// Trie dictionary over a fixed node pool: insert, check and clear by symbol.
// ----------------------------------------------------------------------------
// Words arrive one symbol per item; edges (parent, symbol) -> child live in a
// hash table of 2**clog2(NODES) slots with linear probing. A symbol that
// follows or adds an edge goes through LOOK and CMP (again per extra probe),
// then TAIL; a symbol skipped after a broken path, or an item with no symbol,
// goes to TAIL alone. The item that ends a word adds FIN for the word-end
// lookup and the result. After reset and each clear the table is swept, one
// slot a cycle, over all slots; up to two items queue meanwhile. Results
// queue two deep; the engine takes no new item while that queue is full.
module trie_insert_lookup_core
	import tri_pkg::*;
#(
	parameter int NODES = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] command,
	input  logic [7:0] symbol,
	input  logic       last,
	input  logic       empty_req,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] done_kind,
	output logic       found,
	output logic       full_res,
	output logic [9:0] end_node
);
	item_t   item;
	logic    item_empty;
	logic    item_pop;
	result_t res;

	tri_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.command   (command),
		.symbol    (symbol),
		.last      (last),
		.empty_req (empty_req),
		.full      (full),
		.item_pop  (item_pop),
		.item      (item),
		.item_empty(item_empty)
	);

	tri_engine #(.NODES(NODES)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.item_empty(item_empty),
		.item_pop  (item_pop),
		.res       (res),
		.res_empty (empty),
		.res_pop   (pop)
	);

	assign done_kind = res.done_kind;
	assign found     = res.found;
	assign full_res  = res.full_res;
	assign end_node  = res.end_node;
endmodule

// File: hw/rtl/tri_fifo.sv
// ----------------------------------------------------------------------------
// tri_fifo
// Two-entry queue of register slots with full/empty flags.
// ----------------------------------------------------------------------------
module tri_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);
	logic [W-1:0] mem_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;
	logic         do_push;
	logic         do_pop;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |=> !(cnt_q == 2'd0) || $past(pop))
		else $error("queue lost an entry");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("queue count out of range");
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> wr_q == rd_q)
		else $error("queue pointers disagree with count");
`endif
endmodule

// File: hw/rtl/tri_front.sv
// ----------------------------------------------------------------------------
// tri_front
// Accepts items, drops those with no effect, queues the rest.
// ----------------------------------------------------------------------------
module tri_front
	import tri_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [1:0] command,
	input  logic [7:0] symbol,
	input  logic       last,
	input  logic       empty_req,
	output logic       full,
	input  logic       item_pop,
	output item_t      item,
	output logic       item_empty
);
	item_t in_item;
	logic  keep;
	logic  q_full;
	logic  q_empty;
	logic [$bits(item_t)-1:0] q_dout;

	assign in_item.command   = cmd_t'(command);
	assign in_item.symbol    = symbol;
	assign in_item.last      = last;
	assign in_item.empty_req = empty_req;

	always_comb begin
		unique case (command)
			CMD_INSERT, CMD_CHECK: keep = !(empty_req && !last);
			CMD_CLEAR:             keep = 1'b1;
			default:               keep = 1'b0;
		endcase
	end

	assign full = q_full;

	tri_fifo #(.W($bits(item_t))) u_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push && keep),
		.din   (in_item),
		.full  (q_full),
		.pop   (item_pop),
		.dout  (q_dout),
		.empty (q_empty)
	);

	assign item       = item_t'(q_dout);
	assign item_empty = q_empty;
endmodule

// File: hw/rtl/tri_engine.sv
// ----------------------------------------------------------------------------
// tri_engine
// Walks and extends the trie through a hashed edge table, queues results.
// ----------------------------------------------------------------------------
module tri_engine
	import tri_pkg::*;
#(
	parameter int NODES = 1024
) (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  logic    item_empty,
	output logic    item_pop,
	output result_t res,
	output logic    res_empty,
	input  logic    res_pop
);
	localparam int NW = $clog2(NODES);
	localparam int HD = 1 << NW;
	localparam int CW = NW + 1;

	typedef struct packed {
		logic          vld;
		logic [NW-1:0] parent;
		logic [7:0]    sym;
		logic [NW-1:0] child;
	} ent_t;

	ent_t          tbl [HD];
	logic          wend [NODES];
	ent_t          tbl_rdata_q;
	logic          wend_rdata_q;

	eng_state_t    state_q, state_d;
	logic [NW-1:0] sw_q;
	logic [NW-1:0] slot_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] cursor_q;
	logic          broken_q;
	logic          root_end_q;
	cmd_t          cmd_q;
	logic [7:0]    sym_q;
	logic          last_q;

	logic          tbl_we;
	logic [NW-1:0] tbl_waddr;
	ent_t          tbl_wdata;
	logic          wend_we;
	logic [NW-1:0] wend_addr;
	logic          wend_bit;
	logic          res_push;
	result_t       res_d;
	logic          res_full;
	logic [$bits(result_t)-1:0] res_dout;

	logic          hit;
	logic          can_alloc;
	logic          ok;

	function automatic logic [NW-1:0] slot_of(input logic [NW-1:0] par, input logic [7:0] s);
		logic [15:0] m;
		begin
			m = {8'd0, s} * 16'd40503;
			return par ^ NW'(m);
		end
	endfunction

	assign hit       = tbl_rdata_q.vld && tbl_rdata_q.parent == cursor_q
	                   && tbl_rdata_q.sym == sym_q;
	assign can_alloc = cmd_q == CMD_INSERT && cnt_q < CW'(NODES);
	assign ok        = !broken_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR:  if (sw_q == NW'(HD - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (item_pop) begin
					if (item.command == CMD_CLEAR) begin
						state_d = ST_CLR;
					end else if (!item.empty_req && !broken_q) begin
						state_d = ST_LOOK;
					end else begin
						state_d = ST_TAIL;
					end
				end
			end
			ST_LOOK: state_d = ST_CMP;
			ST_CMP:  state_d = (!hit && tbl_rdata_q.vld) ? ST_LOOK : ST_TAIL;
			ST_TAIL: state_d = last_q ? ST_FIN : ST_IDLE;
			ST_FIN:  state_d = ST_IDLE;
			default: state_d = ST_CLR;
		endcase
	end

	// outputs
	always_comb begin
		item_pop  = 1'b0;
		tbl_we    = 1'b0;
		tbl_waddr = slot_q;
		tbl_wdata = '0;
		wend_we   = 1'b0;
		wend_addr = cursor_q;
		wend_bit  = 1'b0;
		res_push  = 1'b0;
		res_d     = '0;
		unique case (state_q)
			ST_CLR: begin
				tbl_we    = 1'b1;
				tbl_waddr = sw_q;
			end
			ST_IDLE: begin
				item_pop = !item_empty && !res_full;
				if (item_pop && item.command == CMD_CLEAR) begin
					res_push        = 1'b1;
					res_d.done_kind = CMD_CLEAR;
				end
			end
			ST_CMP: begin
				if (!tbl_rdata_q.vld && can_alloc) begin
					tbl_we           = 1'b1;
					tbl_wdata.vld    = 1'b1;
					tbl_wdata.parent = cursor_q;
					tbl_wdata.sym    = sym_q;
					tbl_wdata.child  = cnt_q[NW-1:0];
					wend_we          = 1'b1;
					wend_addr        = cnt_q[NW-1:0];
				end
			end
			ST_FIN: begin
				res_push        = 1'b1;
				res_d.done_kind = cmd_q;
				res_d.end_node  = ok ? 10'(cursor_q) : 10'd0;
				if (cmd_q == CMD_INSERT) begin
					res_d.full_res = !ok;
					wend_we        = ok && cursor_q != '0;
					wend_bit       = 1'b1;
				end else begin
					res_d.found = ok && (cursor_q == '0 ? root_end_q : wend_rdata_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl[tbl_waddr] <= tbl_wdata;
		end
		tbl_rdata_q <= tbl[slot_q];
	end

	always_ff @(posedge clk) begin
		if (wend_we) begin
			wend[wend_addr] <= wend_bit;
		end
		wend_rdata_q <= wend[cursor_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_pop) begin
			cmd_q  <= item.command;
			sym_q  <= item.symbol;
			last_q <= item.last;
			slot_q <= slot_of(cursor_q, item.symbol);
		end else if (state_q == ST_CMP && !hit && tbl_rdata_q.vld) begin
			slot_q <= slot_q + 1'b1; // linear probe, wraps around the table
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			sw_q       <= '0;
			cnt_q      <= CW'(1);
			cursor_q   <= '0;
			broken_q   <= 1'b0;
			root_end_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_CLR: sw_q <= sw_q + 1'b1;
				ST_IDLE: begin
					if (item_pop && item.command == CMD_CLEAR) begin
						sw_q       <= '0;
						cnt_q      <= CW'(1);
						cursor_q   <= '0;
						broken_q   <= 1'b0;
						root_end_q <= 1'b0;
					end
				end
				ST_CMP: begin
					if (hit) begin
						cursor_q <= tbl_rdata_q.child;
					end else if (!tbl_rdata_q.vld) begin
						if (can_alloc) begin
							cursor_q <= cnt_q[NW-1:0];
							cnt_q    <= cnt_q + 1'b1;
						end else begin
							broken_q <= 1'b1;
						end
					end
				end
				ST_FIN: begin
					if (cmd_q == CMD_INSERT && ok && cursor_q == '0) begin
						root_end_q <= 1'b1;
					end
					cursor_q <= '0;
					broken_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	tri_fifo #(.W($bits(result_t))) u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   (res_d),
		.full  (res_full),
		.pop   (res_pop),
		.dout  (res_dout),
		.empty (res_empty)
	);

	assign res = result_t'(res_dout);

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q >= CW'(1) && cnt_q <= CW'(NODES))
		else $error("node count out of range");
	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full queue");
	a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLR |-> !item_pop)
		else $error("item taken during table sweep");
	a_cursor_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q != '0 |-> CW'(cursor_q) < cnt_q)
		else $error("cursor points at an unallocated node");
`endif
endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for trie_insert_lookup_core.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the trie and predicts each result.
// Directed words come first: empty words, prefixes, missing edges, mixed
// commands, clear mid-word and the unused command code. Random words over a
// small alphabet follow. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb;
	import tri_pkg::*;

	localparam int POOL = 1024;
	localparam logic [1:0] CMD_NONE = 2'd3;

	class trie_scoreboard;
		logic [9:0] parent_of [POOL];
		logic [7:0] sym_of [POOL];
		bit marked [POOL];
		int unsigned used;
		int unsigned at;
		bit broken;
		result_t want_q [$];
		int errors;

		function new();
			used = 1;
			at = 0;
			broken = 0;
			marked[0] = 0;
			errors = 0;
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		// accepted item: advance the trie, queue a result if the word ends or on a clear
		function void note(logic [1:0] cmd, logic [7:0] sym, bit lst, bit emp);
			int unsigned child;
			result_t r;
			bit ok;
			if (cmd == CMD_NONE)
				return;
			if (cmd == CMD_CLEAR) begin
				used = 1;
				at = 0;
				broken = 0;
				marked[0] = 0;
				r = '0;
				r.done_kind = CMD_CLEAR;
				want_q.push_back(r);
				return;
			end
			if (!emp && !broken) begin
				child = 0;
				for (int n = 1; n < used; n++)
					if (parent_of[n] == at && sym_of[n] == sym) begin
						child = n;
						break;
					end
				if (child != 0) begin
					at = child;
				end else if (cmd == CMD_INSERT && used < POOL) begin
					parent_of[used] = at[9:0];
					sym_of[used] = sym;
					marked[used] = 0;
					at = used;
					used++;
				end else begin
					broken = 1;
				end
			end
			if (!lst)
				return;
			ok = !broken;
			r = '0;
			r.done_kind = cmd_t'(cmd);
			r.end_node = ok ? at[9:0] : 10'd0;
			if (cmd == CMD_INSERT) begin
				if (ok)
					marked[at] = 1;
				r.full_res = !ok;
			end else begin
				r.found = ok && marked[at];
			end
			want_q.push_back(r);
			at = 0;
			broken = 0;
		endfunction

		task check(result_t got);
			result_t w;
			if (want_q.size() == 0) begin
				report($sformatf("unexpected result %p", got));
				return;
			end
			w = want_q.pop_front();
			if (got.done_kind !== w.done_kind)
				report($sformatf("done_kind %0d, want %0d", got.done_kind, w.done_kind));
			if (got.found !== w.found)
				report($sformatf("found %0b, want %0b", got.found, w.found));
			if (got.full_res !== w.full_res)
				report($sformatf("full_res %0b, want %0b", got.full_res, w.full_res));
			if (got.end_node !== w.end_node)
				report($sformatf("end_node %0d, want %0d", got.end_node, w.end_node));
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic full;
	logic [1:0] command = CMD_INSERT;
	logic [7:0] symbol = '0;
	logic last = 0;
	logic empty_req = 0;
	logic empty;
	logic pop = 0;
	logic [1:0] done_kind;
	logic found;
	logic full_res;
	logic [9:0] end_node;

	bit no_idle = 0;
	trie_scoreboard sb = new();

	trie_insert_lookup_core dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.command(command), .symbol(symbol), .last(last), .empty_req(empty_req),
		.empty(empty), .pop(pop), .done_kind(done_kind), .found(found),
		.full_res(full_res), .end_node(end_node)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(negedge clk) begin
		pop <= arst_n && (no_idle || $urandom_range(99) >= 22);
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check({cmd_t'(done_kind), found, full_res, end_node});
	end

	// entered and left at a falling edge
	task send(logic [1:0] cmd, logic [7:0] sym, bit lst, bit emp);
		while (!no_idle && $urandom_range(99) < 22) begin
			push <= 0;
			@(negedge clk);
		end
		push <= 1;
		command <= cmd;
		symbol <= sym;
		last <= lst;
		empty_req <= emp;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note(cmd, sym, lst, emp);
		@(negedge clk);
	endtask

	task rand_word();
		int len;
		logic [1:0] cmd;
		logic [7:0] sym;
		len = $urandom_range(1, 6);
		cmd = $urandom_range(1) ? CMD_INSERT : CMD_CHECK;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 8)
				cmd = $urandom_range(1) ? CMD_INSERT : CMD_CHECK;
			sym = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
			if ($urandom_range(99) < 2)
				send(CMD_CLEAR, sym, 1'($urandom_range(1)), 1'($urandom_range(1)));
			else if ($urandom_range(99) < 2)
				send(CMD_NONE, sym, 1'($urandom_range(1)), 1'($urandom_range(1)));
			send(cmd, sym, i == len - 1, $urandom_range(99) < 5);
		end
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1;
		// directed
		send(CMD_CHECK, 8'h00, 1, 1);
		send(CMD_INSERT, 8'h00, 1, 1);
		send(CMD_CHECK, 8'hff, 1, 1);
		send(CMD_INSERT, 8'h00, 0, 0);
		send(CMD_INSERT, 8'hff, 0, 0);
		send(CMD_INSERT, 8'h00, 0, 1);
		send(CMD_INSERT, 8'haa, 1, 0);
		send(CMD_CHECK, 8'h00, 0, 0);
		send(CMD_CHECK, 8'hff, 0, 0);
		send(CMD_CHECK, 8'haa, 1, 0);
		send(CMD_CHECK, 8'h00, 1, 0);
		send(CMD_CHECK, 8'h55, 0, 0);
		send(CMD_CHECK, 8'h00, 1, 0);
		send(CMD_CHECK, 8'h00, 0, 0);
		send(CMD_INSERT, 8'hff, 1, 0);
		send(CMD_NONE, 8'h12, 1, 0);
		send(CMD_CHECK, 8'h00, 0, 0);
		send(CMD_CHECK, 8'hff, 1, 0);
		send(CMD_INSERT, 8'h01, 0, 0);
		send(CMD_CLEAR, 8'h00, 0, 0);
		send(CMD_CHECK, 8'h00, 1, 0);
		send(CMD_CHECK, 8'h00, 1, 1);
		// random, with one unbroken stretch and one drain
		for (int w = 0; w < 190; w++) begin
			no_idle = (w >= 60 && w < 90);
			if (w == 100) begin
				push <= 0;
				wait (sb.want_q.size() == 0);
				@(negedge clk);
			end
			rand_word();
		end
		push <= 0;
		wait (sb.want_q.size() == 0);
		repeat (3000) @(posedge clk);
		if (sb.errors == 0 && sb.want_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#200000000;
		$display("tb: failure");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/tri_pkg.sv
hw/rtl/tri_fifo.sv
hw/rtl/tri_front.sv
hw/rtl/tri_engine.sv
hw/rtl/trie_insert_lookup_core.sv
tb/tb.sv
